// File: hw/rtl/pln_pkg.sv
// ----------------------------------------------------------------------------
// pln_pkg
// Shared sizes, register codes, beat types and the truncating multiply used
// by the periodic lattice neighbour block.
// ----------------------------------------------------------------------------
`default_nettype none

package pln_pkg;

	// lattice limits
	localparam int MAX_DIM    = 4;
	localparam int INDEX_BITS = 32;

	// field widths
	localparam int LEN_W     = 16;
	localparam int DIMS_W    = 3;
	localparam int NB_W      = 32;
	localparam int AXIS_W    = 2;
	localparam int SITE_W    = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	// derived sizes
	localparam int AX_BITS   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int EMIT_N    = 2 ** (AX_BITS + 1);
	localparam int DIV_STEPS = (INDEX_BITS + 1) / 2;
	localparam int QW        = 2 * DIV_STEPS;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// job queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS  = 1'd1;
	localparam logic [LEN_W-1:0]     SIDE_RESET      = 16'd2;
	localparam logic [DIMS_W-1:0]    DIMS_RESET      = 3'd2;

	// one decoded site handed from front to back
	typedef struct packed {
		logic [INDEX_BITS-1:0]           base;
		logic [MAX_DIM-1:0][LEN_W-1:0]   digit;
		logic [LEN_W-1:0]                len;
		logic [AX_BITS-1:0]              last_ax;
	} pln_job_t;

	// one neighbour beat
	typedef struct packed {
		logic [INDEX_BITS-1:0] nb;
		logic [AX_BITS-1:0]    axis;
		logic                  direction;
		logic                  already_listed;
		logic                  last;
	} pln_result_t;

	// low INDEX_BITS of a 16 x INDEX_BITS product
	function automatic logic [INDEX_BITS-1:0] mul_lo(input logic [LEN_W-1:0] a,
			input logic [INDEX_BITS-1:0] b);
		logic [INDEX_BITS+LEN_W-1:0] p;
		p = (INDEX_BITS + LEN_W)'(a) * (INDEX_BITS + LEN_W)'(b);
		return p[INDEX_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pln_front.sv
// ----------------------------------------------------------------------------
// pln_front
// Accepts a site index and splits it into base-length digits with a radix-4
// restoring divider, accumulating the wrapped index and the axis weights.
// ----------------------------------------------------------------------------
`default_nettype none

module pln_front import pln_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [LEN_W-1:0]  side_length,
	input  logic [DIMS_W-1:0] dimensions,
	input  logic              push,
	input  logic [SITE_W-1:0] site_index,
	output logic              full,
	output logic              job_valid,
	output pln_job_t          job,
	input  logic              job_ready
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_DIV  = 3'd1;
	localparam logic [2:0] F_MAC  = 3'd2;
	localparam logic [2:0] F_POW  = 3'd3;
	localparam logic [2:0] F_PUSH = 3'd4;

	logic [2:0]                    state_q;
	logic [STEP_W-1:0]             step_q;
	logic [AX_BITS-1:0]            ax_q;
	logic [QW-1:0]                 dq_q;
	logic [LEN_W-1:0]              rem_q;
	logic [LEN_W-1:0]              len_q;
	logic [AX_BITS-1:0]            last_ax_q;
	logic [INDEX_BITS-1:0]         base_q;
	logic [INDEX_BITS-1:0]         pow_q;
	logic [MAX_DIM-1:0][LEN_W-1:0] digit_q;

	logic                  accept;
	logic                  dims_zero;
	logic [LEN_W-1:0]      len_eff;
	int                    dims_sat;
	logic [LEN_W:0]        r1, r2;
	logic                  ge1, ge2;
	logic [LEN_W-1:0]      r1s, r2s;
	logic [QW-1:0]         dq_nx;
	logic [LEN_W-1:0]      mul_a;
	logic [INDEX_BITS-1:0] prod;

	// config sanitizing at accept
	always_comb begin
		len_eff   = (side_length == '0) ? LEN_W'(1) : side_length;
		dims_zero = (dimensions == '0);
		dims_sat  = (int'(dimensions) > MAX_DIM) ? MAX_DIM : int'(dimensions);
	end

	assign accept = push && (state_q == F_IDLE);
	assign full   = (state_q != F_IDLE);

	// two restoring division steps per cycle
	always_comb begin
		r1  = {rem_q, dq_q[QW-1]};
		ge1 = (r1 >= {1'b0, len_q});
		r1s = ge1 ? LEN_W'(r1 - {1'b0, len_q}) : r1[LEN_W-1:0];
		r2  = {r1s, dq_q[QW-2]};
		ge2 = (r2 >= {1'b0, len_q});
		r2s = ge2 ? LEN_W'(r2 - {1'b0, len_q}) : r2[LEN_W-1:0];
		dq_nx = {dq_q[QW-3:0], ge1, ge2};
	end

	// shared multiplier: digit weight or next axis weight
	assign mul_a = (state_q == F_MAC) ? rem_q : len_q;
	assign prod  = mul_lo(mul_a, pow_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			ax_q    <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && !dims_zero) begin
						state_q <= F_DIV;
						step_q  <= '0;
						ax_q    <= '0;
					end
				end
				F_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1))
						state_q <= F_MAC;
				end
				F_MAC: begin
					state_q <= (ax_q == last_ax_q) ? F_PUSH : F_POW;
				end
				F_POW: begin
					ax_q    <= ax_q + 1'b1;
					step_q  <= '0;
					state_q <= F_DIV;
				end
				F_PUSH: begin
					if (job_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					dq_q      <= QW'(site_index[INDEX_BITS-1:0]);
					rem_q     <= '0;
					len_q     <= len_eff;
					last_ax_q <= AX_BITS'(dims_sat - 1);
					base_q    <= '0;
					pow_q     <= INDEX_BITS'(1);
				end
			end
			F_DIV: begin
				dq_q  <= dq_nx;
				rem_q <= r2s;
			end
			F_MAC: begin
				base_q        <= base_q + prod;
				digit_q[ax_q] <= rem_q;
			end
			F_POW: begin
				pow_q <= prod;
				rem_q <= '0;
			end
			default: ;
		endcase
	end

	assign job_valid   = (state_q == F_PUSH);
	assign job.base    = base_q;
	assign job.digit   = digit_q;
	assign job.len     = len_q;
	assign job.last_ax = last_ax_q;

	// divider never runs with a zero divisor
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV) |-> (len_q != '0))
		else $error("divider running with zero length");

endmodule

`default_nettype wire

// File: hw/rtl/pln_queue.sv
// ----------------------------------------------------------------------------
// pln_queue
// Short flop queue of decoded sites between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pln_queue import pln_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	input  pln_job_t wr_job,
	output logic     wr_ready,
	output logic     rd_valid,
	output pln_job_t rd_job,
	input  logic     rd_pop
);

	pln_job_t           slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_wr, do_rd;

	assign wr_ready = (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;
	assign rd_job   = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_job;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("job queue overfilled");

endmodule

`default_nettype wire

// File: hw/rtl/pln_back.sv
// ----------------------------------------------------------------------------
// pln_back
// Walks the axes of one decoded site, builds the plus and minus neighbours
// from the wrapped index and the axis weight, flags repeats and drives the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pln_back import pln_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  pln_job_t    job,
	output logic        job_pop,
	output logic        empty,
	input  logic        pop,
	output pln_result_t result
);

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_MULD  = 3'd1;
	localparam logic [2:0] B_MULW  = 3'd2;
	localparam logic [2:0] B_PLUS  = 3'd3;
	localparam logic [2:0] B_MINUS = 3'd4;

	logic [2:0]            state_q;
	logic [AX_BITS-1:0]    ax_q;
	logic [EMIT_N-1:0]     listed_q;
	logic                  out_valid_q;
	pln_job_t              job_q;
	logic [INDEX_BITS-1:0] pow_q;
	logic [INDEX_BITS-1:0] dp_q;
	logic [INDEX_BITS-1:0] wp_q;
	logic [INDEX_BITS-1:0] emitted_q [EMIT_N];
	pln_result_t           out_q;

	logic [LEN_W-1:0]      d;
	logic [LEN_W-1:0]      mul_a;
	logic [INDEX_BITS-1:0] prod;
	logic                  slot_free;
	logic                  emit;
	logic                  dir;
	logic                  wrap_up;
	logic [INDEX_BITS-1:0] nb;
	logic                  seen;
	logic                  is_last;
	logic [AX_BITS:0]      eidx;

	assign job_pop   = (state_q == B_IDLE) && job_valid;
	assign d         = job_q.digit[ax_q];
	assign mul_a     = (state_q == B_MULD) ? d : job_q.len - 1'b1;
	assign prod      = mul_lo(mul_a, pow_q);
	assign slot_free = !out_valid_q || pop;
	assign dir       = (state_q == B_MINUS);
	assign emit      = slot_free && ((state_q == B_PLUS) || (state_q == B_MINUS));
	assign eidx      = {ax_q, dir};
	assign is_last   = dir && (ax_q == job_q.last_ax);

	// neighbour index from the wrapped index and the axis weight
	always_comb begin
		wrap_up = !(((LEN_W + 1)'(d) + 1'b1) < (LEN_W + 1)'(job_q.len));
		if (!dir)
			nb = wrap_up ? job_q.base - dp_q : job_q.base + pow_q;
		else
			nb = (d != '0) ? job_q.base - pow_q : job_q.base - dp_q + wp_q;
	end

	// repeat check against this run's earlier beats
	always_comb begin
		seen = 1'b0;
		for (int k = 0; k < EMIT_N; k++)
			if (listed_q[k] && (emitted_q[k] == nb))
				seen = 1'b1;
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			ax_q        <= '0;
			listed_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q    <= 1'b1;
				listed_q[eidx] <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						state_q  <= B_MULD;
						ax_q     <= '0;
						listed_q <= '0;
					end
				end
				B_MULD:  state_q <= B_MULW;
				B_MULW:  state_q <= B_PLUS;
				B_PLUS: begin
					if (slot_free)
						state_q <= B_MINUS;
				end
				B_MINUS: begin
					if (slot_free) begin
						if (ax_q == job_q.last_ax) begin
							state_q <= B_IDLE;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= B_MULD;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_q <= job;
					pow_q <= INDEX_BITS'(1);
				end
			end
			B_MULD: dp_q <= prod;
			B_MULW: wp_q <= prod;
			B_MINUS: begin
				// next axis weight: pow * len = pow + (len - 1) * pow
				if (slot_free)
					pow_q <= pow_q + wp_q;
			end
			default: ;
		endcase
		if (emit) begin
			emitted_q[eidx]      <= nb;
			out_q.nb             <= nb;
			out_q.axis           <= ax_q;
			out_q.direction      <= dir;
			out_q.already_listed <= seen;
			out_q.last           <= is_last;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	// the first beat of a run is never a repeat
	a_first_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (state_q == B_PLUS) && (ax_q == '0)) |-> !seen)
		else $error("first neighbour flagged as repeat");

	// a run always closes on a minus beat
	a_last_minus: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> out_q.direction)
		else $error("run closed on a plus beat");

endmodule

`default_nettype wire

// File: hw/rtl/periodic_lattice_neighbours.sv
// ----------------------------------------------------------------------------
// periodic_lattice_neighbours
// Nearest neighbours of a hypercubic lattice site under periodic boundaries.
//
//   channel   handshake            payload
//   input     push / full          site_index
//   result    pop / empty          neighbour_index, axis, direction, already_listed, last
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The front accepts a site, then per axis in use runs the radix-4 divider,
// one digit multiply-add and one weight multiply that the top axis skips,
// and then hands the job off. The back steps through a digit multiply, a
// weight multiply, a plus beat and a minus beat per axis and overlaps the
// next site's division through a two-entry job queue. A stalled result
// holds the back; the front runs on until the job queue is full and then
// holds full high.
// Reset clears all control state and loads side length 2 and two axes.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_lattice_neighbours import pln_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [SITE_W-1:0]    site_index,
	output logic                 empty,
	input  logic                 pop,
	output logic [NB_W-1:0]      neighbour_index,
	output logic [AXIS_W-1:0]    axis,
	output logic                 direction,
	output logic                 already_listed,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [LEN_W-1:0]  side_q;
	logic [DIMS_W-1:0] dims_q;
	logic              job_valid, job_ready, q_valid, q_pop;
	pln_job_t          front_job, q_job;
	pln_result_t       result;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
			dims_q <= DIMS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SIDE_LENGTH: side_q <= cfg_data[LEN_W-1:0];
				REG_DIMENSIONS:  dims_q <= cfg_data[DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	pln_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.side_length (side_q),
		.dimensions  (dims_q),
		.push        (push),
		.site_index  (site_index),
		.full        (full),
		.job_valid   (job_valid),
		.job         (front_job),
		.job_ready   (job_ready)
	);

	pln_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (job_valid),
		.wr_job   (front_job),
		.wr_ready (job_ready),
		.rd_valid (q_valid),
		.rd_job   (q_job),
		.rd_pop   (q_pop)
	);

	pln_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (q_job),
		.job_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// result ports
	assign neighbour_index = NB_W'(result.nb);
	assign axis            = AXIS_W'(result.axis);
	assign direction       = result.direction;
	assign already_listed  = result.already_listed;
	assign last            = result.last;

endmodule

`default_nettype wire
